// ===== rtl/wre_pkg.sv =====
// package for the windowed rms envelope normalizer
// holds sizes, controller state type and control/status structs; no dependencies
package wre_pkg;

    localparam int ENVELOPE_DEPTH = 1024;
    localparam int MAX_WINDOW     = 4096;
    localparam int ADDR_W         = $clog2(ENVELOPE_DEPTH);
    localparam int CNT_W          = ADDR_W + 1;
    localparam int LEN_W          = 13;
    localparam int SUM_W          = 42;
    localparam logic [LEN_W-1:0] LEN_RESET = 13'd480;
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_WINDOW);

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_READ = 2'd1
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_STORE,
        ST_RDMEM,
        ST_NORM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic take_push;
        logic take_read;
        logic div_start;
        logic div_step;
        logic sqrt_step;
        logic store;
        logic norm_start;
        logic norm_step;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic close_req;
        logic div_done;
        logic sqrt_done;
        logic norm_done;
        logic read_hit;
    } stat_t;

endpackage

// ===== rtl/wre_ctrl.sv =====
// controller state machine of the envelope normalizer
// depends on wre_pkg; drives the datapath with ctrl_t and reads stat_t
module wre_ctrl
    import wre_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   in_cmd,
    output logic   in_ready,
    input  logic   out_free,
    input  stat_t  stat,
    output ctrl_t  ctrl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == CMD_READ[0])
                    begin
                        if (out_free)
                        begin
                            state_next = ST_RDMEM;
                        end
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (!stat.close_req)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.div_done)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:  if (stat.sqrt_done) state_next = ST_STORE;
            ST_STORE: state_next = ST_IDLE;
            ST_RDMEM: state_next = stat.read_hit ? ST_NORM : ST_OUT;
            ST_NORM:  if (stat.norm_done) state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = (in_cmd == CMD_READ[0]) ? out_free : 1'b1;
                ctrl.take_push = in_valid && (in_cmd == CMD_PUSH[0]);
                ctrl.take_read = in_valid && (in_cmd == CMD_READ[0]) && out_free;
                ctrl.div_start = ctrl.take_push;
            end
            ST_DIV:   ctrl.div_step = stat.close_req;
            ST_SQRT:  ctrl.sqrt_step = 1'b1;
            ST_STORE: ctrl.store = 1'b1;
            ST_RDMEM: ctrl.norm_start = 1'b1;
            ST_NORM:  ctrl.norm_step = 1'b1;
            ST_OUT:   ctrl.out_load = 1'b1;
            default:  ctrl = '0;
        endcase
    end

endmodule

// ===== rtl/wre_datapath.sv =====
// datapath: square accumulator, serial divider, serial root, serial normalizer, envelope memory
// depends on wre_pkg; steered by ctrl_t from wre_ctrl
module wre_datapath
    import wre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_t             ctrl,
    output stat_t             stat,
    input  logic [LEN_W-1:0]  win_len,
    input  logic signed [15:0] sample,
    input  logic              last_sample,
    output logic [15:0]       res_level,
    output logic              res_valid,
    output logic              res_last,
    output logic              res_ovf
);

    logic [SUM_W-1:0]  sum_reg;
    logic [LEN_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [15:0]       peak_reg;
    logic [CNT_W-1:0]  rptr_reg;
    logic              closed_reg;
    logic              ovf_reg;
    logic              close_reg;

    logic [15:0]       mem [ENVELOPE_DEPTH];
    logic [15:0]       rd_data_reg;
    logic              hit_reg;
    logic              rlast_reg;

    // divider (sum / fill), restoring, one bit per cycle
    logic [SUM_W-1:0]  dq_reg;
    logic [LEN_W:0]    drem_reg;
    logic [5:0]        dcnt_reg;

    // root of 4*mean, 44 bit radicand, one result bit per cycle
    logic [SUM_W+1:0]  rad_reg;
    logic [SUM_W+1:0]  srem_reg;
    logic [22:0]       root_reg;
    logic [4:0]        scnt_reg;

    // normalize v*65535/peak
    logic [31:0]       nq_reg;
    logic [16:0]       nrem_reg;
    logic [4:0]        ncnt_reg;

    logic [LEN_W-1:0]  len_eff;
    logic [15:0]       mag;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_sat;
    logic [LEN_W-1:0]  fill_new;
    logic [LEN_W:0]    dtrial;
    logic [SUM_W+1:0]  strial;
    logic [SUM_W+1:0]  srem_sh;
    logic [16:0]       ntrial;
    logic [15:0]       lvl;

    always_comb
    begin
        len_eff = win_len;
        if (win_len == '0) len_eff = LEN_W'(1);
        if (win_len > LEN_MAX) len_eff = LEN_MAX;
        mag = sample[15] ? 16'(-sample) : sample;
        if (sample == 16'sh8000) mag = 16'h8000;
        sum_add = {1'b0, (closed_reg ? {SUM_W{1'b0}} : sum_reg)}
                + (SUM_W+1)'(32'(mag) * 32'(mag));
        sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        fill_new = (closed_reg ? '0 : fill_reg) + LEN_W'(1);
        dtrial = {drem_reg[LEN_W-1:0], dq_reg[SUM_W-1]} - {1'b0, fill_reg};
        srem_sh = {srem_reg[SUM_W-1:0], rad_reg[SUM_W+1:SUM_W]};
        strial = srem_sh - (SUM_W+2)'({root_reg[20:0], 2'b01});
        ntrial = {nrem_reg[15:0], nq_reg[31]} - {1'b0, peak_reg};
        lvl = (root_reg[22:16] != '0) ? 16'hFFFF : root_reg[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            fill_reg   <= '0;
            total_reg  <= '0;
            peak_reg   <= '0;
            rptr_reg   <= '0;
            closed_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            close_reg  <= 1'b0;
            hit_reg    <= 1'b0;
            res_valid  <= 1'b0;
            res_last   <= 1'b0;
            res_ovf    <= 1'b0;
            res_level  <= '0;
        end
        else
        begin
            if (ctrl.take_push)
            begin
                if (closed_reg)
                begin
                    total_reg <= '0;
                    peak_reg  <= '0;
                    rptr_reg  <= '0;
                    ovf_reg   <= 1'b0;
                end
                sum_reg    <= sum_sat;
                fill_reg   <= fill_new;
                close_reg  <= (fill_new >= len_eff) || last_sample;
                closed_reg <= last_sample;
            end
            if (ctrl.store)
            begin
                if (total_reg < CNT_W'(ENVELOPE_DEPTH))
                begin
                    total_reg <= total_reg + CNT_W'(1);
                    if (lvl > peak_reg) peak_reg <= lvl;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                sum_reg  <= '0;
                fill_reg <= '0;
            end
            if (ctrl.take_read)
            begin
                hit_reg <= closed_reg && (rptr_reg < total_reg);
            end
            if (ctrl.norm_start && hit_reg)
            begin
                rptr_reg <= rptr_reg + CNT_W'(1);
            end
            if (ctrl.out_load)
            begin
                res_valid <= hit_reg;
                res_last  <= hit_reg && rlast_reg;
                res_ovf   <= ovf_reg;
                if (!hit_reg)
                    res_level <= '0;
                else if (peak_reg == '0)
                    res_level <= rd_data_reg;
                else
                    res_level <= (nq_reg[31:16] != '0) ? 16'hFFFF : nq_reg[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.store && total_reg < CNT_W'(ENVELOPE_DEPTH))
            mem[total_reg[ADDR_W-1:0]] <= lvl;
        if (ctrl.take_read)
        begin
            rd_data_reg <= mem[rptr_reg[ADDR_W-1:0]];
            rlast_reg   <= (rptr_reg + CNT_W'(1)) == total_reg;
        end
        if (ctrl.div_start)
        begin
            dcnt_reg <= '0;
        end
        if (ctrl.div_step)
        begin
            if (dcnt_reg == '0)
            begin
                dq_reg   <= sum_reg;
                drem_reg <= '0;
                dcnt_reg <= 6'd1;
            end
            else
            begin
                if (!dtrial[LEN_W])
                    drem_reg <= dtrial;
                else
                    drem_reg <= {drem_reg[LEN_W-1:0], dq_reg[SUM_W-1]};
                dq_reg   <= {dq_reg[SUM_W-2:0], ~dtrial[LEN_W]};
                dcnt_reg <= dcnt_reg + 6'd1;
            end
            rad_reg  <= {dq_reg[SUM_W-2:0], ~dtrial[LEN_W], 2'b00};
            srem_reg <= '0;
            root_reg <= '0;
            scnt_reg <= '0;
        end
        if (ctrl.sqrt_step)
        begin
            rad_reg <= {rad_reg[SUM_W-1:0], 2'b00};
            if (!strial[SUM_W+1])
            begin
                srem_reg <= strial;
                root_reg <= {root_reg[21:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_sh;
                root_reg <= {root_reg[21:0], 1'b0};
            end
            scnt_reg <= scnt_reg + 5'd1;
        end
        if (ctrl.norm_start)
        begin
            nq_reg   <= 32'(rd_data_reg) * 32'd65535;
            nrem_reg <= '0;
            ncnt_reg <= '0;
        end
        if (ctrl.norm_step)
        begin
            if (!ntrial[16])
                nrem_reg <= ntrial;
            else
                nrem_reg <= {nrem_reg[15:0], nq_reg[31]};
            nq_reg   <= {nq_reg[30:0], ~ntrial[16]};
            ncnt_reg <= ncnt_reg + 5'd1;
        end
    end

    assign stat.close_req = close_reg;
    assign stat.div_done  = (dcnt_reg == 6'(SUM_W));
    assign stat.sqrt_done = (scnt_reg == 5'd21);
    assign stat.norm_done = (ncnt_reg == 5'd31);
    assign stat.read_hit  = hit_reg && (peak_reg != '0);

endmodule

// ===== rtl/windowed_rms_envelope_normalizer.sv =====
// top level of the windowed rms envelope normalizer
// depends on wre_pkg, wre_ctrl, wre_datapath; holds the apb register and output stage
//
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    cmd, sample, last_sample
// out       output     out_valid/out_ready  level, entry_valid, last_entry, overflowed
// apb       input      psel/penable/pready  window_length at address 0
//
// a push that closes a window runs divide, root and store; other pushes return to idle
// a read runs the 32 step normalize divide, skipped if no entry is read or the peak is 0
// reset is asynchronous, active low; no clearing pass is needed
// a read is taken only while the output register is empty
module windowed_rms_envelope_normalizer
    import wre_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic signed [15:0] sample,
    input  logic               last_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        level,
    output logic               entry_valid,
    output logic               last_entry,
    output logic               overflowed
);

    logic [LEN_W-1:0] len_reg;
    logic             full_reg;
    ctrl_t            ctrl;
    stat_t            stat;
    logic [15:0]      r_level;
    logic             r_valid, r_last, r_ovf;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? 32'(len_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LEN_RESET;
            full_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == 2'd0)
                len_reg <= pwdata[LEN_W-1:0];
            if (ctrl.out_load)
                full_reg <= 1'b1;
            else if (out_ready)
                full_reg <= 1'b0;
        end
    end

    wre_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_cmd(cmd),
        .in_ready(in_ready), .out_free(!full_reg), .stat(stat), .ctrl(ctrl)
    );

    wre_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat), .win_len(len_reg),
        .sample(sample), .last_sample(last_sample), .res_level(r_level),
        .res_valid(r_valid), .res_last(r_last), .res_ovf(r_ovf)
    );

    assign out_valid   = full_reg;
    assign level       = r_level;
    assign entry_valid = r_valid;
    assign last_entry  = r_last;
    assign overflowed  = r_ovf;

endmodule

// ===== rtl/wre_checker.sv =====
// port level checker for the envelope normalizer
// depends on the top level ports only; bound to the top level below
module wre_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        cmd,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] level,
    input logic        entry_valid,
    input logic        last_entry
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level))
        else $error("output transfer dropped");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_entry |-> entry_valid)
        else $error("last entry without entry");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_valid |-> level == 16'd0)
        else $error("empty read with nonzero level");

    a_noread: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !(in_ready && in_valid && cmd))
        else $error("read taken while output full");

endmodule

bind windowed_rms_envelope_normalizer wre_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .out_valid(out_valid), .out_ready(out_ready), .level(level),
    .entry_valid(entry_valid), .last_entry(last_entry)
);
